FILE: hdl/fisr_pkg.sv
// Package for the fp16 fast inverse square root pipeline.
// Payload structs, fp16 constants and the binary16 multiply/subtract functions.
// No dependencies.
package fisr_pkg;

	typedef struct packed {
		logic [15:0] x_bits;
		logic        last_in;
	} in_item_t;

	typedef struct packed {
		logic [15:0] y_bits;
		logic        last_out;
	} out_item_t;

	localparam logic [15:0] SEED_MAGIC_RST = 16'h59B8;
	localparam logic [15:0] FP16_HALF      = 16'h3800;
	localparam logic [15:0] FP16_3HALF     = 16'h3E00;
	localparam logic [15:0] FP16_QNAN      = 16'h7E00;
	localparam logic [15:0] FP16_INF       = 16'h7C00;

	// Round a nonzero magnitude sig (MSB-justified, 24 bits, bit 23 set)
	// with unbiased exponent e (value = sig/2^23 * 2^e) to binary16, RNE.
	function automatic logic [15:0] fp16_round(input logic s, input logic signed [7:0] e,
			input logic [23:0] sig, input logic sticky_in);
		logic [7:0]  sh;
		logic [35:0] w;
		logic [11:0] q;
		logic        rb, st;
		logic signed [7:0] ee;
		logic [15:0] r;
		sh = 8'd0;
		if (e < -8'sd14) sh = 8'(-8'sd14 - e);
		if (sh > 8'd24) sh = 8'd24;
		// keep 11 bits + round + sticky
		w  = {sig, 12'd0} >> sh;
		q  = {1'b0, w[35:25]};
		rb = w[24];
		st = (|w[23:0]) | sticky_in | ((sh == 8'd24) && (|sig));
		if (rb && (st || q[0])) q = q + 12'd1;
		ee = e;
		if (e < -8'sd14) begin
			r = {s, 5'd0, q[9:0]} | {5'd0, q[10], 10'd0};
		end else begin
			if (q[11]) begin
				q  = q >> 1;
				ee = e + 8'sd1;
			end
			if (ee > 8'sd15) r = {s, 15'h7C00};
			else r = {s, 5'(ee + 8'sd15), q[9:0]};
		end
		return r;
	endfunction

	// Unpack to leading-one significand (11 bits) and exponent.
	function automatic logic [18:0] fp16_unpack(input logic [15:0] a);
		logic [10:0] m;
		logic signed [7:0] e;
		integer i;
		m = {1'b0, a[9:0]};
		e = -8'sd14;
		if (a[14:10] != 5'd0) begin
			m = {1'b1, a[9:0]};
			e = 8'(a[14:10]) - 8'sd15;
		end else begin
			for (i = 0; i < 10; i++) begin
				if (!m[10]) begin
					m = m << 1;
					e = e - 8'sd1;
				end
			end
		end
		return {e, m};
	endfunction

	function automatic logic [15:0] fp16_mul(input logic [15:0] a, input logic [15:0] b);
		logic s, an, bn, ai, bi, az, bz;
		logic [18:0] ua, ub;
		logic [21:0] p;
		logic signed [7:0] e;
		logic [15:0] r;
		s  = a[15] ^ b[15];
		an = (a[14:10] == 5'h1F) && (a[9:0] != 0);
		bn = (b[14:10] == 5'h1F) && (b[9:0] != 0);
		ai = (a[14:10] == 5'h1F) && (a[9:0] == 0);
		bi = (b[14:10] == 5'h1F) && (b[9:0] == 0);
		az = a[14:0] == 15'd0;
		bz = b[14:0] == 15'd0;
		ua = fp16_unpack(a);
		ub = fp16_unpack(b);
		p  = ua[10:0] * ub[10:0];
		e  = ua[18:11] + ub[18:11];
		if (an || bn || (ai && bz) || (bi && az)) r = FP16_QNAN;
		else if (ai || bi) r = {s, 15'h7C00};
		else if (az || bz) r = {s, 15'd0};
		else if (p[21]) r = fp16_round(s, e + 8'sd1, {p, 2'b0}, 1'b0);
		else r = fp16_round(s, e, {p[20:0], 3'b0}, 1'b0);
		return r;
	endfunction

	// a - b
	function automatic logic [15:0] fp16_sub(input logic [15:0] a, input logic [15:0] b);
		logic [15:0] bb, big, sml, r;
		logic [18:0] ub, us;
		logic [7:0] d;
		logic [44:0] mb, ms, sum;
		logic signed [7:0] e;
		logic sb, ss, ai, bi;
		integer i;
		bb = b ^ 16'h8000;
		ai = a[14:10] == 5'h1F;
		bi = bb[14:10] == 5'h1F;
		if (a[14:0] >= bb[14:0]) begin big = a; sml = bb; end
		else begin big = bb; sml = a; end
		ub = fp16_unpack(big);
		us = fp16_unpack(sml);
		sb = big[15];
		ss = sml[15];
		d  = 8'(ub[18:11] - us[18:11]);
		if (d > 8'd40) d = 8'd40;
		mb = {2'b0, ub[10:0], 32'd0};
		ms = (sml[14:0] == 15'd0) ? 45'd0 : ({2'b0, us[10:0], 32'd0} >> d);
		sum = (sb == ss) ? mb + ms : mb - ms;
		// leading one of mb sits two places below the top of sum
		e = ub[18:11] + 8'sd2;
		if ((ai && a[9:0] != 0) || (bi && bb[9:0] != 0) ||
				(ai && bi && a[15] != bb[15])) r = FP16_QNAN;
		else if (ai) r = a;
		else if (bi) r = bb;
		else if (sum == 45'd0) r = 16'd0;
		else begin
			for (i = 0; i < 24; i++) begin
				if (!sum[44]) begin
					sum = sum << 1;
					e = e - 8'sd1;
				end
			end
			r = fp16_round(sb, e, sum[44:21], |sum[20:0]);
		end
		return r;
	endfunction

endpackage

FILE: hdl/fp16_fast_inverse_sqrt.sv
// Top level of the fp16 fast inverse square root pipeline.
// Depends on fisr_pkg.
//
// Streams binary16 values and returns an approximate 1/sqrt(x) per value:
// an integer seed seed_magic - (x >> 1), then two Newton-Raphson steps,
// each binary16 operation rounded to nearest-even. One transfer is accepted
// every cycle while the output does not stall. There are 10 register stages:
// the seed stage, eight stages of one binary16 operation each, and an output
// stage. The whole pipeline advances only when the output register is empty
// or being drained, so a stall holds every stage. The user must write
// seed_magic over the cfg channel while the pipeline is idle; not enforced.
module fp16_fast_inverse_sqrt (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  fisr_pkg::in_item_t in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output fisr_pkg::out_item_t out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [15:0]        cfg_data
);
	import fisr_pkg::*;

	localparam int NS = 10;

	logic [15:0] magic_q;
	logic        adv;
	logic [NS-1:0] v_q;
	logic [15:0] y_q [NS];
	logic [15:0] hx_q [NS];
	logic [15:0] t_q [NS];
	logic        l_q [NS];

	assign cfg_ready = 1'b1;
	assign adv       = !v_q[NS-1] || out_ready;
	assign in_ready  = adv;
	assign out_valid = v_q[NS-1];
	assign out_data  = '{y_bits: y_q[NS-1], last_out: l_q[NS-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q <= SEED_MAGIC_RST;
		end else if (cfg_valid) begin
			magic_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (adv) begin
			v_q <= {v_q[NS-2:0], in_valid};
		end
	end

	// stage 0: seed and 0.5x; stages 1..8: y*y, hx*t, 1.5-t, y*t twice;
	// stage 9 holds the result
	always_ff @(posedge clk) begin
		if (adv) begin
			y_q[0]  <= magic_q - {1'b0, in_data.x_bits[15:1]};
			hx_q[0] <= fp16_mul(in_data.x_bits, FP16_HALF);
			t_q[0]  <= '0;
			l_q[0]  <= in_data.last_in;
			for (int k = 1; k < NS; k++) begin
				hx_q[k] <= hx_q[k-1];
				l_q[k]  <= l_q[k-1];
				case ((k - 1) % 4)
					0: begin
						t_q[k] <= fp16_mul(y_q[k-1], y_q[k-1]);
						y_q[k] <= y_q[k-1];
					end
					1: begin
						t_q[k] <= fp16_mul(hx_q[k-1], t_q[k-1]);
						y_q[k] <= y_q[k-1];
					end
					2: begin
						t_q[k] <= fp16_sub(FP16_3HALF, t_q[k-1]);
						y_q[k] <= y_q[k-1];
					end
					default: begin
						t_q[k] <= t_q[k-1];
						y_q[k] <= fp16_mul(y_q[k-1], t_q[k-1]);
					end
				endcase
			end
		end
	end

endmodule

FILE: test/tb_fp16_fast_inverse_sqrt.sv
// Testbench for fp16_fast_inverse_sqrt: random and directed binary16 streams
// checked against a double-based binary16 predictor held in a scoreboard class.
// Depends on fisr_pkg and the RTL top level.
module tb_fp16_fast_inverse_sqrt;
	import fisr_pkg::*;

	// Tracks the seed register and predicts 1/sqrt(x) for each accepted transfer.
	class rsqrt_scoreboard;
		logic [15:0] magic;
		out_item_t   expected_q[$];
		int          mismatches;

		function new();
			magic = SEED_MAGIC_RST;
			mismatches = 0;
		endfunction

		// Exact widening of a binary16 pattern to a real.
		function real widen(logic [15:0] h);
			logic [63:0] b;
			logic [9:0]  m;
			int          ex;
			b = '0;
			b[63] = h[15];
			m = h[9:0];
			if (h[14:10] == 5'h1F) begin
				b[62:52] = 11'h7FF;
				b[51:42] = m;
			end else if (h[14:10] == 5'd0) begin
				if (m != 0) begin
					logic [10:0] mm;
					mm = {1'b0, m};
					ex = -14;
					while (!mm[10]) begin
						mm = mm << 1;
						ex--;
					end
					b[62:52] = 11'(ex + 1023);
					b[51:42] = mm[9:0];
				end
			end else begin
				b[62:52] = 11'(int'(h[14:10]) - 15 + 1023);
				b[51:42] = m;
			end
			return $bitstoreal(b);
		endfunction

		// Round a real to binary16, nearest-even, gradual underflow.
		function logic [15:0] narrow(real d);
			logic [63:0] b;
			logic [15:0] s;
			logic [52:0] m;
			logic [63:0] rem, half;
			logic [31:0] q;
			int          e, sh;
			b = $realtobits(d);
			s = {b[63], 15'd0};
			if (b[62:52] == 11'h7FF)
				return (b[51:0] != 0) ? FP16_QNAN : (s | FP16_INF);
			if (b[62:52] == 11'd0)
				return s;
			e = int'(b[62:52]) - 1023;
			m = {1'b1, b[51:0]};
			if (e > 15)
				return s | FP16_INF;
			sh = 42;
			if (e < -14)
				sh = sh + (-14 - e);
			if (sh > 63)
				return s;
			q = 32'(m >> sh);
			rem = 64'(m) & ((64'd1 << sh) - 64'd1);
			half = 64'd1 << (sh - 1);
			if (rem > half || (rem == half && q[0]))
				q++;
			if (e >= -14) begin
				if (q == 32'd2048) begin
					q = 32'd1024;
					e++;
				end
				if (e > 15)
					return s | FP16_INF;
				return s | {1'b0, 5'(e + 15), q[9:0]};
			end
			return s | q[15:0];
		endfunction

		function logic [15:0] hmul(logic [15:0] a, logic [15:0] b);
			return narrow(widen(a) * widen(b));
		endfunction

		function logic [15:0] hsub(logic [15:0] a, logic [15:0] b);
			return narrow(widen(a) - widen(b));
		endfunction

		function void note_input(in_item_t it);
			logic [15:0] y, hx, t;
			out_item_t   r;
			y = magic - {1'b0, it.x_bits[15:1]};
			hx = hmul(it.x_bits, FP16_HALF);
			for (int k = 0; k < 2; k++) begin
				t = hmul(y, y);
				t = hmul(hx, t);
				t = hsub(FP16_3HALF, t);
				y = hmul(y, t);
			end
			r.y_bits = y;
			r.last_out = it.last_in;
			expected_q.push_back(r);
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result y=%h last=%b", got.y_bits, got.last_out);
				return;
			end
			want = expected_q.pop_front();
			if (got.y_bits !== want.y_bits || got.last_out !== want.last_out) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected y=%h last=%b, got y=%h last=%b",
						want.y_bits, want.last_out, got.y_bits, got.last_out);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_ready;
	out_item_t   out_data;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;

	rsqrt_scoreboard sb;
	bit idle_on;      // random gaps on both sides
	int hold_cycles;  // receiver hold-off request, counted in the receiver

	fp16_fast_inverse_sqrt u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#5000000;
		$display("tb_fp16_fast_inverse_sqrt: errors");
		$finish;
	end

	// Transfers are observed at the rising edge; inputs only move at falling edges.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_input(in_data);
			if (out_valid && out_ready)
				sb.check_result(out_data);
		end
	end

	// Receiver: random stall bursts, plus a long hold-off on request.
	initial begin
		int burst;
		burst = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				out_ready = 1'b0;
				hold_cycles--;
			end else if (burst > 0) begin
				out_ready = 1'b0;
				burst--;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				out_ready = 1'b0;
				burst = $urandom_range(0, 5);
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	// Called at a falling edge, returns at a falling edge with valid still high.
	task automatic send_x(logic [15:0] x, logic last);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		in_valid = 1'b1;
		in_data.x_bits = x;
		in_data.last_in = last;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic write_magic(logic [15:0] v);
		cfg_valid = 1'b1;
		cfg_data = v;
		do @(posedge clk); while (!cfg_ready);
		sb.magic = v;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Wait until every expected result is back, then let the pipe drain.
	task automatic drain();
		in_valid = 1'b0;
		while (sb.expected_q.size() != 0) @(negedge clk);
		repeat (15) @(negedge clk);
	endtask

	function automatic logic [15:0] random_x();
		logic [15:0] x;
		x = 16'($urandom);
		case ($urandom_range(0, 7))
			0: x[14:10] = 5'h1F;            // inf / NaN
			1: x[14:10] = 5'd0;             // zero / subnormal
			2, 3, 4: x[15] = 1'b0;          // positive sign
			default: ;
		endcase
		return x;
	endfunction

	localparam logic [15:0] DIRECTED [20] = '{
		16'h0000, 16'h8000, 16'h7C00, 16'hFC00, 16'h7E00, 16'h7C01, 16'hFFFF,
		16'h0001, 16'h03FF, 16'h0400, 16'h3C00, 16'h7BFF, 16'h3800, 16'h4400,
		16'hBC00, 16'h5640, 16'h0002, 16'h2E66, 16'hFBFF, 16'h7FFF
	};

	localparam logic [15:0] MAGICS [5] = '{16'h0000, 16'hFFFF, 16'h59B8, 16'h8000, 16'h5A00};

	initial begin
		sb = new();
		idle_on = 1'b1;
		hold_cycles = 0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed values with the reset seed.
		foreach (DIRECTED[i])
			send_x(DIRECTED[i], i[0]);

		for (int ph = 0; ph < 6; ph++) begin
			drain();
			if (ph == 5)
				idle_on = 1'b0;  // closing stretch runs flat out
			write_magic(ph == 5 ? 16'($urandom) : MAGICS[ph]);
			for (int n = 0; n < 190; n++) begin
				// long receiver hold-off while the sender keeps offering
				if (ph == 2 && n == 20)
					hold_cycles = 60;
				send_x(random_x(), 1'($urandom));
			end
		end
		drain();

		if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
			$display("tb_fp16_fast_inverse_sqrt: clean");
		end else begin
			$display("tb_fp16_fast_inverse_sqrt: errors");
		end
		$finish;
	end

endmodule

FILE: sim.f
hdl/fisr_pkg.sv
hdl/fp16_fast_inverse_sqrt.sv
test/tb_fp16_fast_inverse_sqrt.sv
